// ----- hw/rtl/multi_waveform_oscillator_core_assert.svh -----
// Assertion macros for the multi-waveform oscillator core.
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MWO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MWO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mwo_pkg.sv -----
// Types, constants and table builders for the multi-waveform oscillator.
package mwo_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int HARMONICS       = 9;
  localparam int SAMPLE_BITS     = 16;

  localparam int ACTION_W  = 3;
  localparam int PHASE_W   = 32;
  localparam int LFSR_W    = 16;
  localparam int FS_W      = SAMPLE_BITS - 1;
  localparam int QIDX_W    = SINE_TABLE_BITS - 1;
  localparam int QN        = 1 << (SINE_TABLE_BITS - 2);
  localparam int QMAG_W    = 31;
  // harmonic sum magnitude stays below 4.0 in Q30 for up to 16 terms
  localparam int ACC_MAG_W = 32;
  localparam int ACC_W     = ACC_MAG_W + 1;
  localparam int OPND_W    = 32;
  localparam int K2PI_W    = 30;
  localparam int PROD_W    = OPND_W + FS_W;

  typedef logic [ACTION_W-1:0]          action_t;
  typedef logic [PHASE_W-1:0]           phase_t;
  typedef logic [LFSR_W-1:0]            lfsr_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [QIDX_W-1:0]            qidx_t;
  typedef logic [QMAG_W-1:0]            qmag_t;
  typedef qmag_t                        qtab_t [QN+1];

  localparam action_t ACT_SINE        = 3'd0;
  localparam action_t ACT_SQUARE      = 3'd1;
  localparam action_t ACT_TRIANGLE    = 3'd2;
  localparam action_t ACT_ANALOG_SAW  = 3'd3;
  localparam action_t ACT_DIGITAL_SAW = 3'd4;
  localparam action_t ACT_NOISE       = 3'd5;

  // rounding shift applied after the full-scale multiply
  typedef enum logic [1:0] {
    RSH_LFSR,
    RSH_Q30,
    RSH_Q31
  } rshift_t;

  typedef struct packed {
    logic                neg;
    logic [OPND_W-1:0]   mag;
    rshift_t             sh;
  } operand_t;

  localparam logic [FS_W-1:0]   FULL_SCALE      = '1;
  localparam sample_t           SAMPLE_MIN      = {1'b1, {FS_W{1'b0}}};
  localparam lfsr_t             LFSR_SEED       = 16'hACE1;
  localparam lfsr_t             LFSR_HALF       = 16'h8000;
  localparam logic [63:0]       Q30_ONE         = 64'd1073741824;
  localparam logic [63:0]       HALF_PI_Q30     = 64'd1686629713;
  localparam logic [K2PI_W-1:0] TWO_OVER_PI_Q30 = 30'd683565276;
  localparam logic [OPND_W-1:0] HALF_CYCLE      = 32'h8000_0000;
  localparam logic [OPND_W-1:0] QUARTER_CYCLE   = 32'h4000_0000;

  // x^16 + x^14 + x^13 + x^11 + 1, shifting right
  function automatic lfsr_t lfsr_next(input lfsr_t l);
    logic fb;
    fb = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {fb, l[LFSR_W-1:1]};
  endfunction

  // Q30 sine of m/QN quarter turns, Taylor series to t^11 in Horner form
  function automatic qmag_t quarter_sine(input logic [63:0] m);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] h;
    t  = (HALF_PI_Q30 * m + (QN / 2)) / QN;
    t2 = (t * t) >> 30;
    h  = Q30_ONE;
    h  = Q30_ONE - (((t2 * h) >> 30) / 64'd110);
    h  = Q30_ONE - (((t2 * h) >> 30) / 64'd72);
    h  = Q30_ONE - (((t2 * h) >> 30) / 64'd42);
    h  = Q30_ONE - (((t2 * h) >> 30) / 64'd20);
    h  = Q30_ONE - (((t2 * h) >> 30) / 64'd6);
    return qmag_t'((t * h) >> 30);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int m = 0; m <= QN; m++) begin
      tab[m] = quarter_sine(64'(m));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

// ----- hw/rtl/mwo_if.sv -----
// Stream interfaces for oscillator ticks and output samples.
interface mwo_tick_if;
  import mwo_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  phase_t  phase_step;
  modport source (output valid, action, phase_step, input ready);
  modport sink (input valid, action, phase_step, output ready);
endinterface

interface mwo_sample_if;
  import mwo_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

// ----- hw/rtl/multi_waveform_oscillator_core.sv -----
// Multi-waveform phase-accumulator oscillator with a pipelined sample datapath.
//
// tick (sink): one transfer per sample tick, carrying the waveform code in
//   action and the per-sample phase increment in phase_step.
// audio (source): one signed full-scale-saturated sample per tick, in order.
// The sample uses the phase before the increment; the accumulator advances
//   on every tick transfer, the noise LFSR only on noise ticks.
// Pipeline: each sample passes through the nine-stage datapath (tick capture,
//   harmonic indexing, table lookup, two adder levels, 2/pi multiply, rounding,
//   full-scale multiply, output register) before it is presented on audio.
// Throughput: one tick per cycle while audio.ready is high.
// Stalls: each stage holds only while the stage after it is full, so bubbles
//   are squeezed out and tick.ready stays high until the pipeline is full
//   behind a stalled output.
// Reset: synchronous; clears the pipeline, zeroes the phase, reseeds the LFSR
//   and holds tick.ready low while asserted.
module multi_waveform_oscillator_core (
  input  logic clk,
  input  logic rst,
  mwo_tick_if.sink     tick,
  mwo_sample_if.source audio
);
  import mwo_pkg::*;

  localparam int NSTAGE      = 9;
  localparam int NGRP        = (HARMONICS + 3) / 4;
  localparam int NTERM       = NGRP * 4;
  localparam int LFSR_SHIFT  = LFSR_W - 1;
  localparam int Q30_SHIFT   = 30;
  localparam int Q31_SHIFT   = 31;
  localparam int K2PI_PROD_W = ACC_MAG_W + K2PI_W;
  localparam logic [K2PI_PROD_W:0] RND_Y    = (K2PI_PROD_W + 1)'(1) << (Q30_SHIFT - 1);
  localparam logic [PROD_W:0]      RND_LFSR = (PROD_W + 1)'(1) << (LFSR_SHIFT - 1);
  localparam logic [PROD_W:0]      RND_Q30  = (PROD_W + 1)'(1) << (Q30_SHIFT - 1);
  localparam logic [PROD_W:0]      RND_Q31  = (PROD_W + 1)'(1) << (Q31_SHIFT - 1);

  phase_t phase_acc;
  lfsr_t  noise_lfsr;

  logic [NSTAGE-1:0] stage_vld;
  logic [NSTAGE-1:0] stage_en;
  logic              accept;

  action_t act1;
  phase_t  u1;
  lfsr_t   lfsr1;

  action_t  act2;
  operand_t op2;
  operand_t op2_next;
  qidx_t    hm [HARMONICS];
  qidx_t    hm_next [HARMONICS];
  logic     hneg [HARMONICS];
  logic     hneg_next [HARMONICS];

  logic                    saw3;
  operand_t                op3;
  operand_t                op3_next;
  logic signed [ACC_W-1:0] term [NTERM];
  logic signed [ACC_W-1:0] term_next [NTERM];

  logic                    saw4;
  operand_t                op4;
  logic signed [ACC_W-1:0] psum [NGRP];
  logic signed [ACC_W-1:0] psum_next [NGRP];

  logic                    saw5;
  operand_t                op5;
  logic                    acc_neg;
  logic [ACC_MAG_W-1:0]    acc_mag;
  logic signed [ACC_W-1:0] acc_sum;

  logic                   saw6;
  operand_t               op6;
  logic                   neg6;
  logic [K2PI_PROD_W-1:0] prod6;

  operand_t             op7;
  operand_t             op7_next;
  logic [K2PI_PROD_W:0] y_round;
  logic [OPND_W-1:0]    y_mag;

  logic              neg8;
  rshift_t           sh8;
  logic [PROD_W-1:0] prod8;

  logic [PROD_W:0] rsum;
  logic [FS_W-1:0] smag;
  sample_t         sample;
  sample_t         sample_next;

  // ---- flow control
  assign stage_en[NSTAGE-1] = !stage_vld[NSTAGE-1] || audio.ready;
  for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_en
    assign stage_en[k] = !stage_vld[k] || stage_en[k+1];
  end

  assign tick.ready  = stage_en[0] && !rst;
  assign accept      = tick.valid && tick.ready;
  assign audio.valid = stage_vld[NSTAGE-1];
  assign audio.sample = sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld  <= '0;
      phase_acc  <= '0;
      noise_lfsr <= LFSR_SEED;
    end else begin
      stage_vld <= (stage_en & {stage_vld[NSTAGE-2:0], accept}) | (~stage_en & stage_vld);
      if (accept) begin
        phase_acc <= phase_acc + tick.phase_step;
        if (tick.action == ACT_NOISE) begin
          noise_lfsr <= lfsr_next(noise_lfsr);
        end
      end
    end
  end

  // ---- harmonic phases and per-harmonic quotient tables
  for (genvar n = 0; n < HARMONICS; n++) begin : g_harm
    localparam int            HN   = n + 1;
    localparam logic [PHASE_W-1:0] MULT = PHASE_W'(HN);
    phase_t                  hph;
    logic [1:0]              quad;
    logic [QIDX_W-2:0]       r;
    qmag_t                   htab [QN+1];
    logic signed [ACC_W-1:0] tmag;

    for (genvar m = 0; m <= QN; m++) begin : g_ent
      localparam qmag_t HV = qmag_t'((64'(QTAB[m]) + 64'(HN / 2)) / HN);
      assign htab[m] = HV;
    end

    assign hph          = u1 * MULT;
    assign quad         = hph[PHASE_W-1 -: 2];
    assign r            = hph[PHASE_W-3 -: QIDX_W-1];
    assign hm_next[n]   = quad[0] ? qidx_t'(QN) - qidx_t'(r) : qidx_t'(r);
    assign hneg_next[n] = quad[1];

    assign tmag         = $signed({{(ACC_W - QMAG_W){1'b0}}, htab[hm[n]]});
    assign term_next[n] = hneg[n] ? -tmag : tmag;
  end

  for (genvar n = HARMONICS; n < NTERM; n++) begin : g_pad
    assign term_next[n] = '0;
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign psum_next[g] = term[4*g] + term[4*g+1] + term[4*g+2] + term[4*g+3];
  end

  // ---- direct waveforms as sign, magnitude and rounding shift
  always_comb begin
    op2_next = '{neg: 1'b0, mag: '0, sh: RSH_Q30};
    unique case (act1)
      ACT_SQUARE: begin
        op2_next.neg = u1[PHASE_W-1];
        op2_next.mag = QUARTER_CYCLE;
      end
      ACT_TRIANGLE: begin
        unique case (u1[PHASE_W-1 -: 2])
          2'b00: op2_next.mag = u1;
          2'b11: begin
            op2_next.neg = 1'b1;
            op2_next.mag = '0 - u1;
          end
          default: begin
            op2_next.neg = u1 > HALF_CYCLE;
            op2_next.mag = (u1 > HALF_CYCLE) ? u1 - HALF_CYCLE : HALF_CYCLE - u1;
          end
        endcase
      end
      ACT_DIGITAL_SAW: begin
        op2_next.neg = !u1[PHASE_W-1];
        op2_next.mag = u1[PHASE_W-1] ? u1 - HALF_CYCLE : HALF_CYCLE - u1;
        op2_next.sh  = RSH_Q31;
      end
      ACT_NOISE: begin
        op2_next.neg = !lfsr1[LFSR_W-1];
        op2_next.mag = lfsr1[LFSR_W-1] ? OPND_W'(lfsr1 - LFSR_HALF)
                                       : OPND_W'(LFSR_HALF - lfsr1);
        op2_next.sh  = RSH_LFSR;
      end
      default: ;
    endcase
  end

  always_comb begin
    op3_next = op2;
    if (act2 == ACT_SINE) begin
      op3_next.neg = hneg[0];
      op3_next.mag = OPND_W'(QTAB[hm[0]]);
      op3_next.sh  = RSH_Q30;
    end
  end

  // ---- harmonic sum, magnitude and 2/pi scaling
  always_comb begin
    acc_sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      acc_sum = acc_sum + psum[g];
    end
  end

  assign y_round = {1'b0, prod6} + RND_Y;
  assign y_mag   = OPND_W'(y_round >> Q30_SHIFT);

  always_comb begin
    op7_next = op6;
    if (saw6) begin
      op7_next = '{neg: neg6, mag: y_mag, sh: RSH_Q30};
    end
  end

  // ---- full-scale rounding and clamp
  always_comb begin
    unique case (sh8)
      RSH_LFSR: rsum = ({1'b0, prod8} + RND_LFSR) >> LFSR_SHIFT;
      RSH_Q30:  rsum = ({1'b0, prod8} + RND_Q30) >> Q30_SHIFT;
      default:  rsum = ({1'b0, prod8} + RND_Q31) >> Q31_SHIFT;
    endcase
    smag = (rsum > (PROD_W + 1)'(FULL_SCALE)) ? FULL_SCALE : rsum[FS_W-1:0];
    sample_next = neg8 ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
  end

  // ---- datapath registers
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      act1  <= tick.action;
      u1    <= phase_acc;
      lfsr1 <= lfsr_next(noise_lfsr);
    end
    if (stage_en[1]) begin
      act2 <= act1;
      op2  <= op2_next;
      hm   <= hm_next;
      hneg <= hneg_next;
    end
    if (stage_en[2]) begin
      saw3 <= act2 == ACT_ANALOG_SAW;
      op3  <= op3_next;
      term <= term_next;
    end
    if (stage_en[3]) begin
      saw4 <= saw3;
      op4  <= op3;
      psum <= psum_next;
    end
    if (stage_en[4]) begin
      saw5    <= saw4;
      op5     <= op4;
      acc_neg <= acc_sum[ACC_W-1];
      acc_mag <= acc_sum[ACC_W-1] ? ACC_MAG_W'(-acc_sum) : ACC_MAG_W'(acc_sum);
    end
    if (stage_en[5]) begin
      saw6  <= saw5;
      op6   <= op5;
      neg6  <= acc_neg;
      prod6 <= acc_mag * TWO_OVER_PI_Q30;
    end
    if (stage_en[6]) begin
      op7 <= op7_next;
    end
    if (stage_en[7]) begin
      neg8  <= op7.neg;
      sh8   <= op7.sh;
      prod8 <= op7.mag * FULL_SCALE;
    end
    if (stage_en[8]) begin
      sample <= sample_next;
    end
  end

  `include "multi_waveform_oscillator_core_assert.svh"

  `MWO_ASSERT_NEXT(a_phase_advance, tick.valid && tick.ready, phase_acc == $past(phase_acc) + $past(tick.phase_step), "phase accumulator did not advance by the step")
  `MWO_ASSERT_NEXT(a_lfsr_hold, tick.valid && tick.ready && tick.action != ACT_NOISE, $stable(noise_lfsr), "LFSR moved on a non-noise tick")
  `MWO_ASSERT_NOW(a_sample_range, audio.valid, audio.sample != SAMPLE_MIN, "sample outside full scale")

endmodule
